### rtl/core/pmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pointer motion template package
// Shared widths, codes and arithmetic helpers for the pointer motion blocks.
// ----------------------------------------------------------------------------
package pmt_pkg;

    // Field widths.
    localparam int COORD_W = 24;
    localparam int RAD_W   = 23;
    localparam int SCALE_W = 16;
    localparam int IDX_W   = 3;

    // Serial multiplier operand and product widths.
    localparam int MUL_AW = 42;
    localparam int MUL_BW = 27;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // Serial divider and square root widths.
    localparam int DIV_NW = 39;
    localparam int DIV_DW = 25;
    localparam int DIV_QW = 15;
    localparam int SQ_IW  = 50;
    localparam int SQ_RW  = SQ_IW / 2;

    // Input opcodes; the last code is unused and ignored.
    localparam logic [1:0] OP_PEN  = 2'd0;
    localparam logic [1:0] OP_DRAG = 2'd1;
    localparam logic [1:0] OP_MOVE = 2'd2;
    localparam logic [1:0] OP_RSVD = 2'd3;

    // Reshaping modes; the unused mode behaves as cartesian.
    localparam logic [1:0] MODE_CART   = 2'd0;
    localparam logic [1:0] MODE_GRID   = 2'd1;
    localparam logic [1:0] MODE_RADIAL = 2'd2;
    localparam logic [1:0] MODE_RSVD   = 2'd3;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_CX     = 3'd1;
    localparam logic [IDX_W-1:0] REG_CY     = 3'd2;
    localparam logic [IDX_W-1:0] REG_RADIUS = 3'd3;
    localparam logic [IDX_W-1:0] REG_SC1    = 3'd4;
    localparam logic [IDX_W-1:0] REG_SC2    = 3'd5;
    localparam logic [IDX_W-1:0] REG_OFS1   = 3'd6;
    localparam logic [IDX_W-1:0] REG_OFS2   = 3'd7;

    // Register reset values.
    localparam logic [COORD_W-1:0] RST_CENTER = 24'd76800;
    localparam logic [RAD_W-1:0]   RST_RADIUS = 23'd25600;
    localparam logic [SCALE_W-1:0] RST_SC1    = 16'd16384;
    localparam logic [SCALE_W-1:0] RST_SC2    = 16'd1638;

    // Unit vector length in Q1.14.
    localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;

    // Shift right by k, rounding toward zero.
    function automatic logic signed [MUL_PW:0] f_tdiv(input logic signed [MUL_PW:0] v,
                                                      input int unsigned k);
        logic signed [MUL_PW:0] bias;
        bias = v[MUL_PW] ? ((70'sd1 <<< k) - 70'sd1) : 70'sd0;
        return (v + bias) >>> k;
    endfunction

    // Saturate to the signed coordinate range.
    function automatic logic signed [COORD_W-1:0] f_sat24(input logic signed [34:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > 35'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -35'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/pmt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pointer motion template channels
// Valid/ready channels for input events, stroke points and register writes.
// ----------------------------------------------------------------------------
interface pmt_in_if import pmt_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    modport source  (output valid, opcode, pos_x, pos_y, input ready);
    modport sink    (input valid, opcode, pos_x, pos_y, output ready);
    modport monitor (input valid, ready, opcode, pos_x, pos_y);
endinterface

interface pmt_out_if import pmt_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      stroke_start;
    modport source  (output valid, point_x, point_y, stroke_start, input ready);
    modport sink    (input valid, point_x, point_y, stroke_start, output ready);
    modport monitor (input valid, ready, point_x, point_y, stroke_start);
endinterface

interface pmt_cfg_if import pmt_pkg::*;;
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   index;
    logic [COORD_W-1:0] data;
    modport source  (output valid, index, data, input ready);
    modport sink    (input valid, index, data, output ready);
    modport monitor (input valid, ready, index, data);
endinterface

### rtl/core/pmt_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial signed multiplier
// Shift-add multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pmt_mul import pmt_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [MUL_AW-1:0] i_a,
    input  logic signed [MUL_BW-1:0] i_b,
    output logic                     o_done,
    output logic signed [MUL_PW:0]   o_prod
);
    logic              r_busy, r_done, r_neg;
    logic [4:0]        r_cnt;
    logic [MUL_AW-1:0] r_mc;
    logic [MUL_PW-1:0] r_prod;
    logic [MUL_AW-1:0] w_amag;
    logic [MUL_BW-1:0] w_bmag;
    logic [MUL_AW:0]   w_sum;

    // Operand magnitudes; the sign is applied at the end.
    assign w_amag = i_a[MUL_AW-1] ? MUL_AW'(-i_a) : MUL_AW'(i_a);
    assign w_bmag = i_b[MUL_BW-1] ? MUL_BW'(-i_b) : MUL_BW'(i_b);

    // Add the multiplicand into the upper half when the low bit is set.
    assign w_sum = {1'b0, r_prod[MUL_PW-1:MUL_BW]} + (r_prod[0] ? {1'b0, r_mc} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_mc   <= w_amag;
                r_prod <= {{MUL_AW{1'b0}}, w_bmag};
                r_neg  <= i_a[MUL_AW-1] ^ i_b[MUL_BW-1];
            end else if (r_busy) begin
                r_prod <= {w_sum, r_prod[MUL_BW-1:1]};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'(MUL_BW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_neg ? -$signed({1'b0, r_prod}) : $signed({1'b0, r_prod});

endmodule

### rtl/core/pmt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pmt_div import pmt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic              o_done,
    output logic [DIV_QW-1:0] o_quo
);
    logic              r_busy, r_done;
    logic [5:0]        r_cnt;
    logic [DIV_NW-1:0] r_num;
    logic [DIV_DW-1:0] r_den, r_rem;
    logic [DIV_DW:0]   w_trial;
    logic              w_ge;

    // Bring down the next numerator bit and try the subtraction.
    assign w_trial = {r_rem, r_num[DIV_NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? DIV_DW'(w_trial - {1'b0, r_den}) : w_trial[DIV_DW-1:0];
                r_num <= {r_num[DIV_NW-2:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num[DIV_QW-1:0];

endmodule

### rtl/core/pmt_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial square root
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module pmt_sqrt import pmt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SQ_IW-1:0] i_rad,
    output logic             o_done,
    output logic [SQ_RW-1:0] o_root
);
    logic             r_busy, r_done;
    logic [4:0]       r_cnt;
    logic [SQ_IW-1:0] r_s;
    logic [SQ_RW+2:0] r_rem;
    logic [SQ_RW-1:0] r_root;
    logic [SQ_RW+2:0] w_t, w_trial;
    logic             w_ge;

    // Shift in the next two bits and test root*4+1 against the remainder.
    assign w_t     = {r_rem[SQ_RW:0], r_s[SQ_IW-1:SQ_IW-2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = w_t >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_s    <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_s    <= {r_s[SQ_IW-3:0], 2'b00};
                r_rem  <= w_ge ? (w_t - w_trial) : w_t;
                r_root <= {r_root[SQ_RW-2:0], w_ge};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'(SQ_RW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### rtl/core/pointer_motion_template.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pointer motion template
// Reshapes drag motion near a template center and emits stroke points.
// ----------------------------------------------------------------------------
// A pen-down event and a button-up move are handled directly. A drag event
// runs a sequencer over one bit-serial multiplier; inside the radius of action,
// radial mode adds a square root and, unless the pen is on the center, two
// divisions. One event is processed at a time; the finished point sits in an
// output register so the next event is taken while it waits.
module pointer_motion_template import pmt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pmt_in_if.sink    i_in,
    pmt_out_if.source o_out,
    pmt_cfg_if.sink   i_cfg
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RUN  = 5'b00010,
        S_WAIT = 5'b00100,
        S_ADV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    typedef enum logic [19:0] {
        ST_EX = 20'h00001,
        ST_EY = 20'h00002,
        ST_RR = 20'h00004,
        ST_SX = 20'h00008,
        ST_SY = 20'h00010,
        ST_UX = 20'h00020,
        ST_UY = 20'h00040,
        ST_SQ = 20'h00080,
        ST_VX = 20'h00100,
        ST_VY = 20'h00200,
        ST_P1 = 20'h00400,
        ST_P2 = 20'h00800,
        ST_A  = 20'h01000,
        ST_P3 = 20'h02000,
        ST_P4 = 20'h04000,
        ST_B  = 20'h08000,
        ST_Q1 = 20'h10000,
        ST_Q2 = 20'h20000,
        ST_Q3 = 20'h40000,
        ST_Q4 = 20'h80000
    } t_step;

    t_state r_state;
    t_step  r_step;

    // Configuration registers.
    logic [1:0]                r_mode;
    logic signed [COORD_W-1:0] r_cx, r_cy, r_of1, r_of2;
    logic [RAD_W-1:0]          r_rad;
    logic [SCALE_W-1:0]        r_sc1, r_sc2;

    // Pen and raw cursor.
    logic signed [COORD_W-1:0] r_pen_x, r_pen_y, r_raw_x, r_raw_y, r_px, r_py;

    // Working registers.
    logic signed [33:0]       r_dx, r_dy, r_t1;
    logic signed [53:0]       r_acc;
    logic signed [15:0]       r_vx, r_vy;
    logic signed [29:0]       r_a, r_b;
    logic                     r_start;

    // Output register.
    logic                      r_ovalid, r_ostart;
    logic signed [COORD_W-1:0] r_ox, r_oy;

    // Unit connections.
    logic                     w_mul_start, w_div_start, w_sq_start;
    logic                     w_mul_done, w_div_done, w_sq_done, w_done;
    logic signed [MUL_AW-1:0] w_ma;
    logic signed [MUL_BW-1:0] w_mb;
    logic signed [MUL_PW:0]   w_prod;
    logic [DIV_NW-1:0]        w_dnum;
    logic [DIV_QW-1:0]        w_quo;
    logic [SQ_RW-1:0]         w_root;

    // Derived values.
    logic signed [24:0]  w_dx_in, w_dy_in, w_ux, w_uy;
    logic signed [26:0]  w_ex, w_ey;
    logic [24:0]         w_uxmag, w_uymag;
    logic signed [15:0]  w_nvy;
    logic signed [53:0]  w_sum;
    logic signed [33:0]  w_t2;
    logic [33:0]         w_adx, w_ady;
    logic                w_in_acc, w_out_free, w_emit;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_ovalid || o_out.ready;
    assign w_emit     = (r_state == S_DONE) && w_out_free;

    assign w_dx_in = 25'(i_in.pos_x) - 25'(r_raw_x);
    assign w_dy_in = 25'(i_in.pos_y) - 25'(r_raw_y);
    assign w_ex    = 27'(r_pen_x) + 27'(r_dx) - 27'(r_cx);
    assign w_ey    = 27'(r_pen_y) + 27'(r_dy) - 27'(r_cy);
    assign w_ux    = 25'(r_pen_x) - 25'(r_cx);
    assign w_uy    = 25'(r_pen_y) - 25'(r_cy);
    assign w_uxmag = w_ux[24] ? 25'(-w_ux) : 25'(w_ux);
    assign w_uymag = w_uy[24] ? 25'(-w_uy) : 25'(w_uy);
    assign w_nvy   = -r_vy;
    assign w_sum   = r_acc + $signed(w_prod[53:0]);
    assign w_t2    = 34'(f_tdiv(w_prod, 14));
    assign w_adx   = r_dx[33] ? 34'(-r_dx) : 34'(r_dx);
    assign w_ady   = r_dy[33] ? 34'(-r_dy) : 34'(r_dy);
    assign w_done  = w_mul_done || w_div_done || w_sq_done;

    // Unit start strobes and operand selection for the current step.
    always_comb begin
        w_ma        = '0;
        w_mb        = '0;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_sq_start  = 1'b0;
        w_dnum      = (r_step == ST_VX) ? {w_uxmag, 14'd0} : {w_uymag, 14'd0};
        if (r_state == S_RUN) begin
            w_mul_start = 1'b1;
            unique case (r_step)
                ST_EX: begin w_ma = 42'(w_ex); w_mb = w_ex; end
                ST_EY: begin w_ma = 42'(w_ey); w_mb = w_ey; end
                ST_RR: begin w_ma = 42'({1'b0, r_rad}); w_mb = 27'({1'b0, r_rad}); end
                ST_SX: begin w_ma = 42'(r_dx); w_mb = 27'({1'b0, r_sc1}); end
                ST_SY: begin w_ma = 42'(r_dy); w_mb = 27'({1'b0, r_sc2}); end
                ST_UX: begin w_ma = 42'(w_ux); w_mb = 27'(w_ux); end
                ST_UY: begin w_ma = 42'(w_uy); w_mb = 27'(w_uy); end
                ST_SQ: begin w_mul_start = 1'b0; w_sq_start = 1'b1; end
                ST_VX: begin w_mul_start = 1'b0; w_div_start = 1'b1; end
                ST_VY: begin w_mul_start = 1'b0; w_div_start = 1'b1; end
                ST_P1: begin w_ma = 42'(r_dx); w_mb = 27'(r_vx); end
                ST_P2: begin w_ma = 42'(r_dy); w_mb = 27'(r_vy); end
                ST_A:  begin w_ma = r_acc[41:0]; w_mb = 27'({1'b0, r_sc1}); end
                ST_P3: begin w_ma = 42'(r_dx); w_mb = 27'(w_nvy); end
                ST_P4: begin w_ma = 42'(r_dy); w_mb = 27'(r_vx); end
                ST_B:  begin w_ma = r_acc[41:0]; w_mb = 27'({1'b0, r_sc2}); end
                ST_Q1: begin w_ma = 42'(r_a); w_mb = 27'(r_vx); end
                ST_Q2: begin w_ma = 42'(r_b); w_mb = 27'(w_nvy); end
                ST_Q3: begin w_ma = 42'(r_a); w_mb = 27'(r_vy); end
                ST_Q4: begin w_ma = 42'(r_b); w_mb = 27'(r_vx); end
                default: w_mul_start = 1'b0;
            endcase
        end
    end

    pmt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    pmt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_dnum),
        .i_den   (w_root),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    pmt_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_rad   (r_acc[SQ_IW-1:0]),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CART;
            r_cx   <= RST_CENTER;
            r_cy   <= RST_CENTER;
            r_rad  <= RST_RADIUS;
            r_sc1  <= RST_SC1;
            r_sc2  <= RST_SC2;
            r_of1  <= '0;
            r_of2  <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_MODE:   r_mode <= i_cfg.data[1:0];
                REG_CX:     r_cx   <= i_cfg.data;
                REG_CY:     r_cy   <= i_cfg.data;
                REG_RADIUS: r_rad  <= i_cfg.data[RAD_W-1:0];
                REG_SC1:    r_sc1  <= i_cfg.data[SCALE_W-1:0];
                REG_SC2:    r_sc2  <= i_cfg.data[SCALE_W-1:0];
                REG_OFS1:   r_of1  <= i_cfg.data;
                REG_OFS2:   r_of2  <= i_cfg.data;
                default:    r_mode <= r_mode;
            endcase
        end
    end

    // Event sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= ST_EX;
            r_pen_x  <= '0;
            r_pen_y  <= '0;
            r_raw_x  <= '0;
            r_raw_y  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        unique case (i_in.opcode)
                            OP_PEN: begin
                                r_pen_x <= i_in.pos_x;
                                r_pen_y <= i_in.pos_y;
                                r_start <= 1'b1;
                                r_state <= S_DONE;
                            end
                            OP_DRAG: begin
                                r_px    <= i_in.pos_x;
                                r_py    <= i_in.pos_y;
                                r_dx    <= 34'(w_dx_in);
                                r_dy    <= 34'(w_dy_in);
                                r_start <= 1'b0;
                                r_step  <= ST_EX;
                                r_state <= S_RUN;
                            end
                            OP_MOVE: begin
                                r_raw_x <= i_in.pos_x;
                                r_raw_y <= i_in.pos_y;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_RUN: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_done) begin
                        r_state <= S_RUN;
                        unique case (r_step)
                            ST_EX: begin r_acc <= 54'(w_prod); r_step <= ST_EY; end
                            ST_EY: begin r_acc <= w_sum; r_step <= ST_RR; end
                            ST_RR: begin
                                // Reshape only strictly inside the radius of action.
                                if (w_prod > 70'(r_acc)) begin
                                    r_step <= (r_mode == MODE_RADIAL) ? ST_UX : ST_SX;
                                end else begin
                                    r_state <= S_ADV;
                                end
                            end
                            ST_SX: begin r_t1 <= w_t2; r_step <= ST_SY; end
                            ST_SY: begin
                                r_state <= S_ADV;
                                if (r_mode == MODE_GRID) begin
                                    if (w_adx > w_ady) r_dy <= w_t2;
                                    else               r_dx <= r_t1;
                                end else begin
                                    r_dx <= r_t1 + 34'(r_of1);
                                    r_dy <= w_t2 + 34'(r_of2);
                                end
                            end
                            ST_UX: begin r_acc <= 54'(w_prod); r_step <= ST_UY; end
                            ST_UY: begin r_acc <= w_sum; r_step <= ST_SQ; end
                            ST_SQ: begin
                                // A pen on the center takes the unit vector along x.
                                if (w_root == '0) begin
                                    r_vx   <= UNIT_Q14;
                                    r_vy   <= '0;
                                    r_step <= ST_P1;
                                end else begin
                                    r_step <= ST_VX;
                                end
                            end
                            ST_VX: begin
                                r_vx   <= w_ux[24] ? -16'(w_quo) : 16'(w_quo);
                                r_step <= ST_VY;
                            end
                            ST_VY: begin
                                r_vy   <= w_uy[24] ? -16'(w_quo) : 16'(w_quo);
                                r_step <= ST_P1;
                            end
                            ST_P1: begin r_acc <= 54'(w_prod); r_step <= ST_P2; end
                            ST_P2: begin r_acc <= w_sum; r_step <= ST_A; end
                            ST_A: begin
                                r_a    <= 30'(f_tdiv(w_prod, 28)) + 30'(r_of1);
                                r_step <= ST_P3;
                            end
                            ST_P3: begin r_acc <= 54'(w_prod); r_step <= ST_P4; end
                            ST_P4: begin r_acc <= w_sum; r_step <= ST_B; end
                            ST_B: begin
                                r_b    <= 30'(f_tdiv(w_prod, 28)) + 30'(r_of2);
                                r_step <= ST_Q1;
                            end
                            ST_Q1: begin r_acc <= 54'(w_prod); r_step <= ST_Q2; end
                            ST_Q2: begin
                                r_dx   <= 34'(f_tdiv(70'(w_sum), 14));
                                r_step <= ST_Q3;
                            end
                            ST_Q3: begin r_acc <= 54'(w_prod); r_step <= ST_Q4; end
                            ST_Q4: begin
                                r_dy    <= 34'(f_tdiv(70'(w_sum), 14));
                                r_state <= S_ADV;
                            end
                            default: r_state <= S_ADV;
                        endcase
                    end
                end
                S_ADV: begin
                    // Advance the pen with saturation and record the raw cursor.
                    r_pen_x <= f_sat24(35'(r_pen_x) + 35'(r_dx));
                    r_pen_y <= f_sat24(35'(r_pen_y) + 35'(r_dy));
                    r_raw_x <= r_px;
                    r_raw_y <= r_py;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The finished point loads the output register once it is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_emit) begin
            r_ovalid <= 1'b1;
            r_ox     <= r_pen_x;
            r_oy     <= r_pen_y;
            r_ostart <= r_start;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign i_cfg.ready        = 1'b1;
    assign o_out.valid        = r_ovalid;
    assign o_out.point_x      = r_ox;
    assign o_out.point_y      = r_oy;
    assign o_out.stroke_start = r_ostart;

endmodule
